/* hw/rtl/hmtq_pkg.sv */
// Package for the hotkey match table: operation and status codes,
// sequencer states and the packed table entry.
// No dependencies.
`default_nettype none

package hmtq_pkg;

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_PRESS      = 2'd2,
		OP_POLL       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADKEY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_MOVE,
		S_POLL
	} state_t;

	localparam int unsigned ID_W  = 32;
	localparam int unsigned KEY_W = 8;
	localparam int unsigned MOD_W = 4;

	typedef struct packed {
		logic signed [ID_W-1:0]  id;
		logic        [KEY_W-1:0] key;
		logic        [MOD_W-1:0] mods;
	} entry_t;

	localparam int unsigned ENTRY_W = ID_W + KEY_W + MOD_W;

endpackage

`default_nettype wire

/* hw/rtl/hmtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hmtq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output      logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* hw/rtl/hotkey_match_table_with_queue.sv */
// Hotkey match table with a ring of triggered ids: top level and sequencer.
// Depends on hmtq_pkg and hmtq_ram.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------------------
//   command   | start / busy       | op, hotkey_id, key_code, modifier_set
//   result    | done (1-cycle)     | status, polled_id
//
// Register finishes at the accept edge and the result follows in the next cycle.
// Poll of an empty ring likewise; a non-empty poll reads the ring RAM in S_POLL.
// Unregister and key press walk the table with one shared comparator, one
// entry per cycle, up to the hit or the last entry; unregister then writes the
// last entry into the hole in S_MOVE.
// Reset clears entry count, ring pointers, done and the sequencer; the RAMs are not
// cleared (only entries below the count and occupied ring slots are read).
// The receiver cannot stall: done is a strobe and each result beat is taken
// as it appears. busy is high while a walk or ring read is in progress.
`default_nettype none

module hotkey_match_table_with_queue
	import hmtq_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned RING_DEPTH  = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output      logic                    busy,
	input  wire logic [1:0]              op,
	input  wire logic signed [ID_W-1:0]  hotkey_id,
	input  wire logic [KEY_W-1:0]        key_code,
	input  wire logic [MOD_W-1:0]        modifier_set,
	output      logic                    done,
	output      logic [1:0]              status,
	output      logic signed [ID_W-1:0]  polled_id
);

	// table index, entry count and ring pointer widths
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned RW = $clog2(RING_DEPTH);

	state_t state_q, state_d;

	// latched command beat
	op_t                   op_q;
	logic signed [ID_W-1:0] id_q;
	logic [KEY_W-1:0]      key_q;
	logic [MOD_W-1:0]      mods_q;

	logic [IW-1:0] idx_q, idx_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [RW-1:0] head_q, head_d, tail_q, tail_d;

	// result register
	logic                   done_q, done_d;
	status_t                status_q, status_d;
	logic signed [ID_W-1:0] polled_q, polled_d;

	// table RAM
	logic          tbl_we;
	logic [IW-1:0] tbl_waddr, tbl_raddr;
	entry_t        tbl_wdata, tbl_rdata;

	// ring RAM
	logic                   ring_we;
	logic signed [ID_W-1:0] ring_rdata;

	logic          accept;
	logic          cmp_hit;
	logic [CW-1:0] last_cnt;
	logic [IW-1:0] last_idx, idx_inc;
	logic [RW-1:0] head_nxt, tail_nxt;
	logic          ring_empty, ring_full;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	assign last_cnt = cnt_q - CW'(1);
	assign last_idx = last_cnt[IW-1:0];
	assign idx_inc  = idx_q + IW'(1);

	// wrap pointers at any ring depth, not only powers of two
	assign head_nxt   = (head_q == RW'(RING_DEPTH - 1)) ? '0 : head_q + RW'(1);
	assign tail_nxt   = (tail_q == RW'(RING_DEPTH - 1)) ? '0 : tail_q + RW'(1);
	assign ring_empty = (head_q == tail_q);
	assign ring_full  = (tail_nxt == head_q);

	// shared comparator: id on unregister, key code and modifiers on press
	assign cmp_hit = (op_q == OP_UNREGISTER) ? (tbl_rdata.id == id_q)
	                 : ((tbl_rdata.key == key_q) && (tbl_rdata.mods == mods_q));

	hmtq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_tbl_ram (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (tbl_waddr),
		.wr_data (tbl_wdata),
		.rd_addr (tbl_raddr),
		.rd_data (tbl_rdata)
	);

	// ring read always looks at the head; data is ready the cycle after accept
	hmtq_ram #(
		.WIDTH (ID_W),
		.DEPTH (RING_DEPTH)
	) u_ring_ram (
		.clk     (clk),
		.wr_en   (ring_we),
		.wr_addr (tail_q),
		.wr_data (tbl_rdata.id),
		.rd_addr (head_q),
		.rd_data (ring_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, datapath controls and result
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		head_d    = head_q;
		tail_d    = tail_q;
		done_d    = 1'b0;
		status_d  = ST_OK;
		polled_d  = '0;
		tbl_we    = 1'b0;
		tbl_waddr = idx_q;
		tbl_wdata = tbl_rdata;
		tbl_raddr = '0;
		ring_we   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				// keep entry 0 on the read port so a walk starts with data in hand
				tbl_raddr = '0;
				if (accept) begin
					idx_d = '0;
					unique case (op_t'(op))
						OP_REGISTER: begin
							done_d = 1'b1;
							if (cnt_q >= CW'(TABLE_DEPTH)) begin
								status_d = ST_FULL;
							end else if (key_code == '0) begin
								status_d = ST_BADKEY;
							end else begin
								// append at the fill count
								tbl_we    = 1'b1;
								tbl_waddr = cnt_q[IW-1:0];
								tbl_wdata = '{id: hotkey_id, key: key_code, mods: modifier_set};
								cnt_d     = cnt_q + CW'(1);
							end
						end
						OP_UNREGISTER, OP_PRESS: begin
							if (cnt_q == '0) begin
								done_d = 1'b1;
							end else begin
								state_d = S_CMP;
							end
						end
						OP_POLL: begin
							if (ring_empty) begin
								done_d = 1'b1;
							end else begin
								state_d = S_POLL;
							end
						end
					endcase
				end
			end

			S_CMP: begin
				if (cmp_hit) begin
					if (op_q == OP_UNREGISTER) begin
						// fetch the last entry to fill the hole
						tbl_raddr = last_idx;
						state_d   = S_MOVE;
					end else begin
						// queue the id unless the ring is full; drop otherwise
						if (!ring_full) begin
							ring_we = 1'b1;
							tail_d  = tail_nxt;
						end
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end else if (idx_q == last_idx) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					// advance to the next entry
					tbl_raddr = idx_inc;
					idx_d     = idx_inc;
				end
			end

			S_MOVE: begin
				tbl_we    = 1'b1;
				tbl_waddr = idx_q;
				tbl_wdata = tbl_rdata;
				cnt_d     = last_cnt;
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end

			S_POLL: begin
				polled_d = ring_rdata;
				head_d   = head_nxt;
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			head_q <= head_d;
			tail_q <= tail_d;
			done_q <= done_d;
		end
	end

	// payload registers: command beat, walk index, result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			id_q   <= hotkey_id;
			key_q  <= key_code;
			mods_q <= modifier_set;
		end
		idx_q    <= idx_d;
		status_q <= status_d;
		polled_q <= polled_d;
	end

	assign done      = done_q;
	assign status    = status_q;
	assign polled_id = polled_q;

	// every finished walk or ring read delivers a result beat
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1))))
		else $error("entry count moved by more than one");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= RW'(RING_DEPTH - 1)) && (tail_q <= RW'(RING_DEPTH - 1)))
		else $error("ring pointer out of range");

	a_err_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (polled_id == '0))
		else $error("error status with a polled id");

endmodule

`default_nettype wire

/* sim/hotkey_match_checker.sv */
// Checker for the hotkey match table: watches the command and result channels,
// predicts every result beat and compares it field by field.
// Depends on hmtq_pkg.
`default_nettype none

module hotkey_match_checker
	import hmtq_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned RING_DEPTH  = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    busy,
	input  wire logic [1:0]              op,
	input  wire logic signed [ID_W-1:0]  hotkey_id,
	input  wire logic [KEY_W-1:0]        key_code,
	input  wire logic [MOD_W-1:0]        modifier_set,
	input  wire logic                    done,
	input  wire logic [1:0]              status,
	input  wire logic signed [ID_W-1:0]  polled_id,
	output int                           results_due,
	output int                           mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t                status;
		logic signed [ID_W-1:0] polled;
	} outcome_t;

	entry_t                 hot_table [TABLE_DEPTH];
	int unsigned            hot_count;
	logic signed [ID_W-1:0] id_ring [RING_DEPTH];
	int unsigned            ring_rd;
	int unsigned            ring_wr;
	outcome_t               outcome_q [$];
	int                     err_total;

	// Apply one command to the shadow table and ring; return the result beat it causes.
	function automatic outcome_t run_hotkey_op(op_t cmd, logic signed [ID_W-1:0] id,
			logic [KEY_W-1:0] key, logic [MOD_W-1:0] mods);
		outcome_t    res;
		int unsigned i;
		int unsigned nxt;
		res.status = ST_OK;
		res.polled = '0;
		case (cmd)
			OP_REGISTER: begin
				if (hot_count >= TABLE_DEPTH)
					res.status = ST_FULL;
				else if (key == '0)
					res.status = ST_BADKEY;
				else begin
					hot_table[hot_count].id   = id;
					hot_table[hot_count].key  = key;
					hot_table[hot_count].mods = mods;
					hot_count++;
				end
			end
			OP_UNREGISTER: begin
				for (i = 0; i < hot_count; i++) begin
					if (hot_table[i].id == id) begin
						hot_table[i] = hot_table[hot_count - 1];
						hot_count--;
						break;
					end
				end
			end
			OP_PRESS: begin
				for (i = 0; i < hot_count; i++) begin
					if (hot_table[i].key == key && hot_table[i].mods == mods) begin
						nxt = (ring_wr + 1) % RING_DEPTH;
						if (nxt != ring_rd) begin
							id_ring[ring_wr] = hot_table[i].id;
							ring_wr = nxt;
						end
						break;
					end
				end
			end
			OP_POLL: begin
				if (ring_rd != ring_wr) begin
					res.polled = id_ring[ring_rd];
					ring_rd = (ring_rd + 1) % RING_DEPTH;
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			hot_count = 0;
			ring_rd = 0;
			ring_wr = 0;
			outcome_q.delete();
			err_total = 0;
			results_due <= 0;
			mismatches <= 0;
		end else begin
			// retire the result beat first, so a command accepted on the same edge queues behind it
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result beat with nothing expected: status %0d, polled_id %0d",
						status, polled_id);
					err_total++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, status);
						err_total++;
					end
					if (polled_id !== want.polled) begin
						$error("polled_id mismatch: expected %0d, got %0d",
							want.polled, polled_id);
						err_total++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(run_hotkey_op(op_t'(op), hotkey_id, key_code,
					modifier_set));
			results_due <= outcome_q.size();
			mismatches <= err_total;
		end
	end

endmodule

`default_nettype wire

/* sim/tb_hotkey_match_table_with_queue.sv */
// Testbench top for hotkey_match_table_with_queue: clock, reset, command stimulus
// and the verdict. Depends on hmtq_pkg, the block and hotkey_match_checker.
`default_nettype none

module tb_hotkey_match_table_with_queue
	import hmtq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned RING_DEPTH  = 8;
	localparam int          ITEM_TARGET = 1050;
	// drain time after the last expected beat, sized from the worst table walk
	localparam int          DRAIN_CYCLES = 2 * (TABLE_DEPTH + 2) + 4;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             op;
	logic signed [ID_W-1:0] hotkey_id;
	logic [KEY_W-1:0]       key_code;
	logic [MOD_W-1:0]       modifier_set;
	logic                   done;
	logic [1:0]             status;
	logic signed [ID_W-1:0] polled_id;
	int                     results_due;
	int                     mismatches;

	// stimulus-side bookkeeping: which hotkeys should be live, used only to aim commands
	entry_t                 live_keys [$];
	bit                     gaps_on;
	int                     cmds_sent;

	hotkey_match_table_with_queue #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.RING_DEPTH  (RING_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.hotkey_id    (hotkey_id),
		.key_code     (key_code),
		.modifier_set (modifier_set),
		.done         (done),
		.status       (status),
		.polled_id    (polled_id)
	);

	hotkey_match_checker #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.RING_DEPTH  (RING_DEPTH)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.hotkey_id    (hotkey_id),
		.key_code     (key_code),
		.modifier_set (modifier_set),
		.done         (done),
		.status       (status),
		.polled_id    (polled_id),
		.results_due  (results_due),
		.mismatches   (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("[hotkey_match_table_with_queue] ERROR");
		$finish;
	end

	// Send one command beat. Hold start low for a random gap, then hold the beat
	// until an edge sees start high with busy low. Return on the following falling
	// edge, so a back-to-back beat keeps start high without a glitch.
	task automatic issue(input op_t cmd, input logic signed [ID_W-1:0] id,
			input logic [KEY_W-1:0] key, input logic [MOD_W-1:0] mods);
		int gap;
		int i;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		op           <= cmd;
		hotkey_id    <= id;
		key_code     <= key;
		modifier_set <= mods;
		do @(posedge clk); while (busy);
		@(negedge clk);
		// mirror the table roughly so later presses and removals hit live entries
		if (cmd == OP_REGISTER && key != '0 && live_keys.size() < TABLE_DEPTH)
			live_keys.push_back('{id: id, key: key, mods: mods});
		if (cmd == OP_UNREGISTER) begin
			for (i = 0; i < live_keys.size(); i++) begin
				if (live_keys[i].id == id) begin
					live_keys.delete(i);
					break;
				end
			end
		end
		cmds_sent++;
	endtask

	// Ids lean toward the corners: zero, minus one and both signed extremes.
	function automatic logic signed [ID_W-1:0] pick_id();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'sh7fff_ffff;
			3: return 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Press a live hotkey most of the time; otherwise any key and modifier set.
	task automatic press_one();
		entry_t pick;
		if (live_keys.size() != 0 && $urandom_range(0, 4) != 0) begin
			pick = live_keys[$urandom_range(0, live_keys.size() - 1)];
			issue(OP_PRESS, $urandom, pick.key, pick.mods);
		end else
			issue(OP_PRESS, $urandom, 8'($urandom_range(0, 255)),
				4'($urandom_range(0, 15)));
	endtask

	initial begin : stimulus
		int     n;
		int     k;
		entry_t pick;

		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_REGISTER;
		hotkey_id    = '0;
		key_code     = '0;
		modifier_set = '0;
		gaps_on      = 1'b1;
		cmds_sent    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty poll, bad key, extremes, duplicate keys, misses,
		// absent removal, move-last on removal, id zero through the ring.
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_REGISTER,   32'sh0000_0005, 8'h00, 4'h3);
		issue(OP_REGISTER,   32'sh7fff_ffff, 8'hff, 4'hf);
		issue(OP_REGISTER,   32'sh8000_0000, 8'h01, 4'h0);
		issue(OP_REGISTER,   32'sh0000_0011, 8'h01, 4'h0);
		issue(OP_PRESS,      32'sh0000_0000, 8'hff, 4'hf);
		issue(OP_PRESS,      32'sh0000_0000, 8'h01, 4'h0);
		issue(OP_PRESS,      32'sh0000_0000, 8'h01, 4'h1);
		issue(OP_PRESS,      32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_UNREGISTER, 32'sh1234_5678, 8'h00, 4'h0);
		issue(OP_UNREGISTER, 32'sh7fff_ffff, 8'h00, 4'h0);
		issue(OP_PRESS,      32'sh0000_0000, 8'h01, 4'h0);
		issue(OP_REGISTER,   32'sh0000_0000, 8'h80, 4'h5);
		issue(OP_PRESS,      32'sh0000_0000, 8'h80, 4'h5);
		issue(OP_REGISTER,   32'shffff_ffff, 8'h7e, 4'ha);
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_UNREGISTER, 32'sh8000_0000, 8'h00, 4'h0);
		issue(OP_UNREGISTER, 32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_PRESS,      32'sh0000_0000, 8'h80, 4'h5);
		issue(OP_POLL,       32'sh0000_0000, 8'h00, 4'h0);
		issue(OP_UNREGISTER, 32'shffff_ffff, 8'h00, 4'h0);

		// Random: bursts of one kind of command (or mixed noise), so the table fills
		// past its depth, the ring overflows and drains, and entries get removed from
		// everywhere. About a third of the bursts run without gaps.
		while (cmds_sent < ITEM_TARGET) begin
			gaps_on = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 10);
					for (k = 0; k < n; k++)
						issue(OP_REGISTER, pick_id(),
							($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
							4'($urandom_range(0, 15)));
				end
				2, 3, 4: begin
					n = $urandom_range(3, 14);
					for (k = 0; k < n; k++)
						press_one();
				end
				5, 6: begin
					n = $urandom_range(1, 9);
					for (k = 0; k < n; k++)
						issue(OP_POLL, $urandom, 8'($urandom_range(0, 255)),
							4'($urandom_range(0, 15)));
				end
				7, 8: begin
					n = $urandom_range(1, 16);
					for (k = 0; k < n; k++) begin
						if (live_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
							pick = live_keys[$urandom_range(0, live_keys.size() - 1)];
							issue(OP_UNREGISTER, pick.id, 8'($urandom_range(0, 255)),
								4'($urandom_range(0, 15)));
						end else
							issue(OP_UNREGISTER, pick_id(), 8'($urandom_range(0, 255)),
								4'($urandom_range(0, 15)));
					end
				end
				default: begin
					// noise: any command, any field values
					for (k = 0; k < 12; k++)
						issue(op_t'($urandom_range(0, 3)), $urandom,
							8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
				end
			endcase
		end

		// drop start, drain every expected beat, then watch for stray ones
		start <= 1'b0;
		while (results_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[hotkey_match_table_with_queue] OK");
		else
			$display("[hotkey_match_table_with_queue] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
